// ===== rtl/dssm_pkg.sv =====
// shared types and constants for the dual stack shared memory unit
// no dependencies; every other file but dssm_ram imports this package
`timescale 1ns / 1ps

package dssm_pkg;

  localparam int unsigned TOTAL_DEPTH_DEF = 1024;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DEPTH_W  = 10;
  localparam int unsigned STATUS_W = 2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic STACK_ONE = 1'b0;
  localparam logic STACK_TWO = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic exec;      // apply the request held on the input ports
    logic load_top;  // capture ram read data as the new top
  } dssm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read; // request is a pop that leaves the stack non-empty
  } dssm_stat_t;

endpackage

// ===== rtl/dual_stack_shared_memory_unit.sv =====
// two stacks in one ram: stack one in the lower half, stack two in the upper half
// results: a push or a failed request shows its result in the cycle after accept;
//   a pop that leaves its stack non-empty first passes the read state (registered ram read of new top)
// requests: the controller handles one request at a time and takes no new one until the
//   result is taken; the single ram read port sets the pop path
// reset: asynchronous, active low; clears both depths; ram contents are not cleared
`timescale 1ns / 1ps

module dual_stack_shared_memory_unit #(
  parameter int unsigned TOTAL_DEPTH = dssm_pkg::TOTAL_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic                               which_stack_i,
  input  logic signed [dssm_pkg::DATA_W-1:0] value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dssm_pkg::STATUS_W-1:0]      status_o,
  output logic [dssm_pkg::DEPTH_W-1:0]       depth_one_o,
  output logic [dssm_pkg::DEPTH_W-1:0]       depth_two_o,
  output logic signed [dssm_pkg::DATA_W-1:0] top_one_o,
  output logic                               top_one_valid_o,
  output logic signed [dssm_pkg::DATA_W-1:0] top_two_o,
  output logic                               top_two_valid_o
);

  import dssm_pkg::*;

  // command and status between sequencer and datapath
  dssm_cmd_t  cmd;
  dssm_stat_t stat;

  // sequencer: idle accepts a request, read loads the registered ram read of the
  // new top word after a pop, resp holds the result until it is taken
  dssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: both stack pointers, cached top words and the shared ram;
  // a push writes the ram and its cached top at once, a pop that leaves
  // data behind reloads the cached top from the word below the old top
  dssm_datapath #(
    .TOTAL_DEPTH (TOTAL_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .which_stack_i   (which_stack_i),
    .value_i         (value_i),
    .status_o        (status_o),
    .depth_one_o     (depth_one_o),
    .depth_two_o     (depth_two_o),
    .top_one_o       (top_one_o),
    .top_one_valid_o (top_one_valid_o),
    .top_two_o       (top_two_o),
    .top_two_valid_o (top_two_valid_o)
  );

endmodule

// ===== rtl/dssm_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing but the clock
`timescale 1ns / 1ps

module dssm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dssm_datapath.sv =====
// stack pointers, cached top words, status register and the shared ram
// depends on dssm_pkg and dssm_ram
`timescale 1ns / 1ps

module dssm_datapath #(
  parameter int unsigned TOTAL_DEPTH = dssm_pkg::TOTAL_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dssm_pkg::dssm_cmd_t                cmd_i,
  output dssm_pkg::dssm_stat_t               stat_o,
  input  logic                               kind_i,
  input  logic                               which_stack_i,
  input  logic signed [dssm_pkg::DATA_W-1:0] value_i,
  output logic [dssm_pkg::STATUS_W-1:0]      status_o,
  output logic [dssm_pkg::DEPTH_W-1:0]       depth_one_o,
  output logic [dssm_pkg::DEPTH_W-1:0]       depth_two_o,
  output logic signed [dssm_pkg::DATA_W-1:0] top_one_o,
  output logic                               top_one_valid_o,
  output logic signed [dssm_pkg::DATA_W-1:0] top_two_o,
  output logic                               top_two_valid_o
);

  import dssm_pkg::*;

  localparam int unsigned HALF_ONE = TOTAL_DEPTH / 2;
  localparam int unsigned HALF_TWO = TOTAL_DEPTH - HALF_ONE;
  localparam int unsigned AW       = $clog2(TOTAL_DEPTH);
  localparam int unsigned CW       = $clog2(HALF_TWO + 1);
  localparam int unsigned EW       = (CW > DEPTH_W) ? CW : DEPTH_W;

  logic [CW-1:0]       count_one_q, count_one_d;
  logic [CW-1:0]       count_two_q, count_two_d;
  logic [DATA_W-1:0]   top_one_q, top_one_d;
  logic [DATA_W-1:0]   top_two_q, top_two_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                which_q, which_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [EW-1:0] depth_one_ext;
  logic [EW-1:0] depth_two_ext;

  always_comb begin
    count_one_d = count_one_q;
    count_two_d = count_two_q;
    top_one_d   = top_one_q;
    top_two_d   = top_two_q;
    status_d    = status_q;
    which_d     = which_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(count_one_q);
    ram_re      = 1'b0;
    ram_raddr   = AW'(count_one_q) - AW'(2);
    stat_o.need_read = 1'b0;

    if (which_stack_i == STACK_ONE) begin
      ram_raddr = AW'(count_one_q) - AW'(2);
      if (kind_i == KIND_POP && count_one_q >= CW'(2)) begin
        stat_o.need_read = 1'b1;
      end
    end else begin
      ram_raddr = AW'(HALF_ONE) + AW'(count_two_q) - AW'(2);
      if (kind_i == KIND_POP && count_two_q >= CW'(2)) begin
        stat_o.need_read = 1'b1;
      end
    end

    if (cmd_i.exec) begin
      which_d  = which_stack_i;
      status_d = STATUS_OK;
      ram_re   = stat_o.need_read;
      if (which_stack_i == STACK_ONE) begin
        if (kind_i == KIND_PUSH) begin
          if (count_one_q < CW'(HALF_ONE)) begin
            ram_we      = 1'b1;
            ram_waddr   = AW'(count_one_q);
            top_one_d   = value_i;
            count_one_d = count_one_q + CW'(1);
          end else begin
            status_d = STATUS_OVERFLOW;
          end
        end else begin
          if (count_one_q != '0) begin
            count_one_d = count_one_q - CW'(1);
          end else begin
            status_d = STATUS_UNDERFLOW;
          end
        end
      end else begin
        if (kind_i == KIND_PUSH) begin
          if (count_two_q < CW'(HALF_TWO)) begin
            ram_we      = 1'b1;
            ram_waddr   = AW'(HALF_ONE) + AW'(count_two_q);
            top_two_d   = value_i;
            count_two_d = count_two_q + CW'(1);
          end else begin
            status_d = STATUS_OVERFLOW;
          end
        end else begin
          if (count_two_q != '0) begin
            count_two_d = count_two_q - CW'(1);
          end else begin
            status_d = STATUS_UNDERFLOW;
          end
        end
      end
    end

    if (cmd_i.load_top) begin
      if (which_q == STACK_ONE) begin
        top_one_d = ram_rdata;
      end else begin
        top_two_d = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_one_q <= '0;
      count_two_q <= '0;
    end else begin
      count_one_q <= count_one_d;
      count_two_q <= count_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_one_q <= top_one_d;
    top_two_q <= top_two_d;
    status_q  <= status_d;
    which_q   <= which_d;
  end

  dssm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TOTAL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign depth_one_ext   = EW'(count_one_q);
  assign depth_two_ext   = EW'(count_two_q);
  assign depth_one_o     = depth_one_ext[DEPTH_W-1:0];
  assign depth_two_o     = depth_two_ext[DEPTH_W-1:0];
  assign status_o        = status_q;
  assign top_one_valid_o = (count_one_q != '0);
  assign top_two_valid_o = (count_two_q != '0);
  assign top_one_o       = top_one_valid_o ? top_one_q : '0;
  assign top_two_o       = top_two_valid_o ? top_two_q : '0;

endmodule

// ===== rtl/dssm_ctrl.sv =====
// request sequencer: accept, optional ram read, hold result until taken
// depends on dssm_pkg
`timescale 1ns / 1ps

module dssm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  dssm_pkg::dssm_stat_t stat_i,
  output dssm_pkg::dssm_cmd_t  cmd_o
);

  import dssm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.exec     = 1'b0;
    cmd_o.load_top = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.need_read ? ST_READ : ST_RESP;
        end
      end
      ST_READ: begin
        cmd_o.load_top = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);

endmodule

// ===== rtl/dssm_checker.sv =====
// port-level checks for dual_stack_shared_memory_unit, bound to the top level
// depends on dssm_pkg
`timescale 1ns / 1ps

module dssm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               kind_i,
  input logic                               which_stack_i,
  input logic signed [dssm_pkg::DATA_W-1:0] value_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [dssm_pkg::STATUS_W-1:0]      status_o,
  input logic [dssm_pkg::DEPTH_W-1:0]       depth_one_o,
  input logic [dssm_pkg::DEPTH_W-1:0]       depth_two_o,
  input logic signed [dssm_pkg::DATA_W-1:0] top_one_o,
  input logic                               top_one_valid_o,
  input logic signed [dssm_pkg::DATA_W-1:0] top_two_o,
  input logic                               top_two_valid_o
);

  import dssm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(depth_one_o) && $stable(depth_two_o) &&
      $stable(top_one_o) && $stable(top_two_o))
    else $error("stalled result changed");

  // one request in flight: after an accept the input side stalls
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK || status_o == STATUS_OVERFLOW ||
      status_o == STATUS_UNDERFLOW))
    else $error("undefined status code");

  // an empty stack shows zero depth and a zero top
  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!top_one_valid_o || !top_two_valid_o) |->
      (top_one_valid_o || (depth_one_o == '0 && top_one_o == '0)) &&
      (top_two_valid_o || (depth_two_o == '0 && top_two_o == '0)))
    else $error("empty stack shows data");

endmodule

bind dual_stack_shared_memory_unit dssm_checker u_dssm_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for dual_stack_shared_memory_unit: push/pop requests
// on both stacks, random idling on both channels, results checked in order
// depends on dssm_pkg and the rtl of dual_stack_shared_memory_unit
`timescale 1ns / 1ps

module testbench;
  import dssm_pkg::*;

  localparam int unsigned TOTAL_DEPTH = TOTAL_DEPTH_DEF;
  localparam int unsigned HALF_ONE    = TOTAL_DEPTH / 2;
  localparam int unsigned HALF_TWO    = TOTAL_DEPTH - HALF_ONE;
  // watchdog limit, set with a wide margin over the length of the whole run
  localparam int unsigned CYCLE_LIMIT = 800000;

  // one result as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [DEPTH_W-1:0]       depth_one;
    logic [DEPTH_W-1:0]       depth_two;
    logic signed [DATA_W-1:0] top_one;
    logic                     top_one_valid;
    logic signed [DATA_W-1:0] top_two;
    logic                     top_two_valid;
  } stack_result_t;

  // mirror of both stacks plus the queue of results still owed by the block
  class stack_board;
    logic [DATA_W-1:0] words [TOTAL_DEPTH];
    int unsigned       depth_one;
    int unsigned       depth_two;
    stack_result_t     owed_q[$];
    int                errors;

    function new();
      depth_one = 0;
      depth_two = 0;
      errors    = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // apply one accepted request to the mirror and queue the result it owes
    function void note_request(input logic kind, input logic which,
                               input logic [DATA_W-1:0] value);
      stack_result_t r;
      r.status = STATUS_OK;
      if (which == STACK_ONE) begin
        if (kind == KIND_PUSH) begin
          if (depth_one < HALF_ONE) begin
            words[depth_one] = value;
            depth_one++;
          end else begin
            r.status = STATUS_OVERFLOW;
          end
        end else if (depth_one > 0) begin
          depth_one--;
        end else begin
          r.status = STATUS_UNDERFLOW;
        end
      end else begin
        if (kind == KIND_PUSH) begin
          if (depth_two < HALF_TWO) begin
            words[HALF_ONE + depth_two] = value;
            depth_two++;
          end else begin
            r.status = STATUS_OVERFLOW;
          end
        end else if (depth_two > 0) begin
          depth_two--;
        end else begin
          r.status = STATUS_UNDERFLOW;
        end
      end
      r.depth_one     = DEPTH_W'(depth_one);
      r.depth_two     = DEPTH_W'(depth_two);
      r.top_one_valid = (depth_one != 0);
      r.top_two_valid = (depth_two != 0);
      r.top_one       = (depth_one != 0) ? words[depth_one - 1] : '0;
      r.top_two       = (depth_two != 0) ? words[HALF_ONE + depth_two - 1] : '0;
      owed_q.push_back(r);
    endfunction

    task check_result(input stack_result_t got);
      stack_result_t want;
      if (owed_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.depth_one !== want.depth_one)
          report($sformatf("depth_one got %0d want %0d", got.depth_one, want.depth_one));
        if (got.depth_two !== want.depth_two)
          report($sformatf("depth_two got %0d want %0d", got.depth_two, want.depth_two));
        if (got.top_one !== want.top_one)
          report($sformatf("top_one got %h want %h", got.top_one, want.top_one));
        if (got.top_one_valid !== want.top_one_valid)
          report($sformatf("top_one_valid got %b want %b",
                           got.top_one_valid, want.top_one_valid));
        if (got.top_two !== want.top_two)
          report($sformatf("top_two got %h want %h", got.top_two, want.top_two));
        if (got.top_two_valid !== want.top_two_valid)
          report($sformatf("top_two_valid got %b want %b",
                           got.top_two_valid, want.top_two_valid));
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel, all known from time zero
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i        = KIND_PUSH;
  logic                     which_stack_i = STACK_ONE;
  logic signed [DATA_W-1:0] value_i       = '0;

  // result channel
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic [DEPTH_W-1:0]       depth_one_o;
  logic [DEPTH_W-1:0]       depth_two_o;
  logic signed [DATA_W-1:0] top_one_o;
  logic                     top_one_valid_o;
  logic signed [DATA_W-1:0] top_two_o;
  logic                     top_two_valid_o;

  stack_board  board;
  int unsigned requests_sent = 0;
  int unsigned cycles        = 0;
  logic        hold_off      = 1'b0;  // long receiver hold-off, driven by its own process
  bit          calm          = 1'b0;  // no idling on either side while set

  dual_stack_shared_memory_unit #(
    .TOTAL_DEPTH(TOTAL_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .which_stack_i  (which_stack_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .depth_one_o    (depth_one_o),
    .depth_two_o    (depth_two_o),
    .top_one_o      (top_one_o),
    .top_one_valid_o(top_one_valid_o),
    .top_two_o      (top_two_o),
    .top_two_valid_o(top_two_valid_o)
  );

  always #5 clk_i = ~clk_i;

  // idle length: mostly none or short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // data values: mostly random, sometimes the signed extremes, zero and the all-ones pattern
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one request and hold it until the block takes it;
  // called at a rising edge, returns at the edge where the request was accepted
  task send_request(input logic kind, input logic which, input logic [DATA_W-1:0] value);
    int gap;
    gap = calm ? 0 : pick_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    which_stack_i <= which;
    value_i       <= value;
    // in_stall_o is sampled before the edge updates take effect
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(kind, which, value);
    requests_sent++;
  endtask

  // a run of random requests; share_one and push_pct in percent steer the mix
  task run_segment(input int count, input int share_one, input int push_pct);
    logic which;
    logic kind;
    for (int i = 0; i < count; i++) begin
      which = ($urandom_range(0, 99) < share_one) ? STACK_ONE : STACK_TWO;
      kind  = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
      send_request(kind, which, pick_value());
    end
  endtask

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL dual_stack_shared_memory_unit");
      $finish;
    end
  end

  // result side: check every accepted result, stall in random runs
  initial begin : result_side
    int            stall_run;
    stack_result_t got;
    stall_run = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.status        = status_o;
        got.depth_one     = depth_one_o;
        got.depth_two     = depth_two_o;
        got.top_one       = top_one_o;
        got.top_one_valid = top_one_valid_o;
        got.top_two       = top_two_o;
        got.top_two_valid = top_two_valid_o;
        board.check_result(got);
      end
      if (stall_run == 0 && !calm && $urandom_range(0, 3) == 0)
        stall_run = pick_len();
      out_stall_i <= hold_off || (stall_run != 0);
      if (stall_run != 0)
        stall_run--;
    end
  end

  // back-pressure: once the stack-one fill is under way, hold the result side
  // for a long stretch while requests keep coming, so the block backs up
  initial begin : pressure
    wait (requests_sent >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: underflow on both empty stacks first
    send_request(KIND_POP, STACK_ONE, $urandom);
    send_request(KIND_POP, STACK_TWO, $urandom);
    // pushes with extreme and alternating patterns on both halves
    send_request(KIND_PUSH, STACK_ONE, 32'h7fff_ffff);
    send_request(KIND_PUSH, STACK_TWO, 32'h8000_0000);
    send_request(KIND_PUSH, STACK_ONE, 32'h0000_0000);
    send_request(KIND_PUSH, STACK_TWO, 32'hffff_ffff);
    send_request(KIND_PUSH, STACK_ONE, 32'h0000_0001);
    send_request(KIND_PUSH, STACK_TWO, 32'h5555_5555);
    send_request(KIND_PUSH, STACK_ONE, 32'haaaa_aaaa);
    // drain stack one to empty, including its very last element, then one too many
    repeat (4) send_request(KIND_POP, STACK_ONE, $urandom);
    send_request(KIND_POP, STACK_ONE, $urandom);
    // same for stack two
    repeat (3) send_request(KIND_POP, STACK_TWO, $urandom);
    send_request(KIND_POP, STACK_TWO, $urandom);

    // random: a mixed warm-up with no idling at all
    calm = 1'b1;
    run_segment(100, 50, 60);
    calm = 1'b0;
    // fill stack one past full so overflow shows up, with some stack-two traffic
    run_segment(650, 95, 97);
    // fill stack two past full; the stray stack-one pushes now overflow too
    run_segment(650, 5, 97);
    // mostly pops on both stacks
    run_segment(200, 50, 10);
    in_valid_i <= 1'b0;

    // wait for every owed result, then a few more cycles for stray output
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (board.errors == 0)
      $display("PASS dual_stack_shared_memory_unit");
    else
      $display("FAIL dual_stack_shared_memory_unit");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dssm_pkg.sv
rtl/dssm_ram.sv
rtl/dssm_datapath.sv
rtl/dssm_ctrl.sv
rtl/dual_stack_shared_memory_unit.sv
rtl/dssm_checker.sv
tb/sv/testbench.sv
